// ===== hw/rtl/afx_pkg.sv =====
// afx_pkg: types and constants shared by the api frame transmitter modules
// no dependencies; compile before every other file of the block
package afx_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_START_RAW = 2'd0;
    localparam logic [1:0] OP_START_TX  = 2'd1;
    localparam logic [1:0] OP_PAYLOAD   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_ID  = 2'd0;
    localparam logic [1:0] CFG_RADIUS    = 2'd1;
    localparam logic [1:0] CFG_TX_OPTS   = 2'd2;

    localparam logic [7:0]  FRAME_ID_RESET = 8'h01;
    localparam logic [7:0]  DELIM_BYTE     = 8'h7E;
    localparam logic [7:0]  TYPE_TX_REQ    = 8'h10;
    localparam logic [7:0]  SUM_BASE       = 8'hFF;
    localparam logic [15:0] HDR_EXTRA      = 16'd14;
    localparam logic [15:0] MAX_TX_PAYLOAD = 16'd65521;

    // last header step of each command kind
    localparam logic [4:0] STEP_RAW_LAST  = 5'd2;
    localparam logic [4:0] STEP_TX_LAST   = 5'd16;
    localparam logic [4:0] STEP_DATA_LAST = 5'd0;

    typedef enum logic [1:0] {
        KIND_RAW  = 2'd0,
        KIND_TX   = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    // command passed from the classifier to the byte sequencer
    typedef struct packed {
        t_kind        kind;
        logic         last;      // closes the frame with a checksum
        logic [15:0]  flen;
        logic [63:0]  dest;
        logic [15:0]  net;
        logic [7:0]   data;
    } t_cmd;

    typedef struct packed {
        logic [7:0] frame_id;
        logic [7:0] radius;
        logic [7:0] tx_options;
    } t_cfg;

endpackage

// ===== hw/rtl/afx_front.sv =====
// afx_front: classifies input words and tracks the open frame
// depends on afx_pkg
module afx_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_operation,
    input  logic [63:0]         i_dest_address,
    input  logic [15:0]         i_network_address,
    input  logic [15:0]         i_payload_length,
    input  logic [7:0]          i_data_byte,
    output logic                o_cmd_push,
    output afx_pkg::t_cmd       o_cmd
);
    import afx_pkg::*;

    logic [15:0] r_bytes_left, n_bytes_left;
    logic        r_frame_open, n_frame_open;
    logic [15:0] plen_tx;
    logic [15:0] count;

    always_comb begin
        plen_tx = (i_payload_length > MAX_TX_PAYLOAD) ? MAX_TX_PAYLOAD : i_payload_length;
        count   = (i_operation == OP_START_TX) ? plen_tx : i_payload_length;

        o_cmd.kind = KIND_DATA;
        o_cmd.last = 1'b0;
        o_cmd.flen = (i_operation == OP_START_TX) ? plen_tx + HDR_EXTRA : i_payload_length;
        o_cmd.dest = i_dest_address;
        o_cmd.net  = i_network_address;
        o_cmd.data = i_data_byte;
        o_cmd_push   = 1'b0;
        n_bytes_left = r_bytes_left;
        n_frame_open = r_frame_open;

        case (i_operation) inside
            OP_START_RAW, OP_START_TX: begin
                o_cmd.kind = (i_operation == OP_START_TX) ? KIND_TX : KIND_RAW;
                o_cmd.last = (count == 16'd0);
                if (i_accept) begin
                    o_cmd_push   = 1'b1;
                    n_bytes_left = count;
                    n_frame_open = (count != 16'd0);
                end
            end
            OP_PAYLOAD: begin
                o_cmd.last = (r_bytes_left == 16'd1);
                if (i_accept && r_frame_open) begin
                    o_cmd_push   = 1'b1;
                    n_bytes_left = r_bytes_left - 16'd1;
                    n_frame_open = (r_bytes_left != 16'd1);
                end
            end
            default: begin
                o_cmd_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_frame_open <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_frame_open <= n_frame_open;
        end
    end

endmodule

// ===== hw/rtl/afx_cmd_fifo.sv =====
// afx_cmd_fifo: short command queue between classifier and sequencer
// depends on afx_pkg
module afx_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  afx_pkg::t_cmd       i_data,
    output logic                o_full,
    input  logic                i_pop,
    output afx_pkg::t_cmd       o_data,
    output logic                o_empty
);
    import afx_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/afx_back.sv =====
// afx_back: byte sequencer, running checksum and output register
// depends on afx_pkg
module afx_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_empty,
    input  afx_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    input  afx_pkg::t_cfg       i_cfg,
    input  logic                i_out_pop,
    output logic                o_out_valid,
    output logic [7:0]          o_tx_byte,
    output logic                o_frame_end
);
    import afx_pkg::*;

    t_cmd       r_cmd, n_cmd;
    logic       r_busy, n_busy;
    logic [4:0] r_step, n_step;
    logic [7:0] r_sum, n_sum;
    logic       r_out_valid, n_out_valid;
    logic [7:0] r_out_byte, n_out_byte;
    logic       r_out_end, n_out_end;

    logic       out_ready, fire, last, load, is_csum, summed;
    logic [4:0] hdr_last;
    logic [7:0] cur_byte;

    always_comb begin
        case (r_cmd.kind)
            KIND_RAW: hdr_last = STEP_RAW_LAST;
            KIND_TX:  hdr_last = STEP_TX_LAST;
            default:  hdr_last = STEP_DATA_LAST;
        endcase
        is_csum = (r_step == hdr_last + 5'd1);

        summed   = 1'b0;
        cur_byte = SUM_BASE - r_sum;
        if (!is_csum) begin
            case (r_cmd.kind)
                KIND_RAW: begin
                    case (r_step)
                        5'd0:    cur_byte = DELIM_BYTE;
                        5'd1:    cur_byte = r_cmd.flen[15:8];
                        default: cur_byte = r_cmd.flen[7:0];
                    endcase
                end
                KIND_TX: begin
                    summed = (r_step >= 5'd3);
                    case (r_step)
                        5'd0:    cur_byte = DELIM_BYTE;
                        5'd1:    cur_byte = r_cmd.flen[15:8];
                        5'd2:    cur_byte = r_cmd.flen[7:0];
                        5'd3:    cur_byte = TYPE_TX_REQ;
                        5'd4:    cur_byte = i_cfg.frame_id;
                        5'd5:    cur_byte = r_cmd.dest[63:56];
                        5'd6:    cur_byte = r_cmd.dest[55:48];
                        5'd7:    cur_byte = r_cmd.dest[47:40];
                        5'd8:    cur_byte = r_cmd.dest[39:32];
                        5'd9:    cur_byte = r_cmd.dest[31:24];
                        5'd10:   cur_byte = r_cmd.dest[23:16];
                        5'd11:   cur_byte = r_cmd.dest[15:8];
                        5'd12:   cur_byte = r_cmd.dest[7:0];
                        5'd13:   cur_byte = r_cmd.net[15:8];
                        5'd14:   cur_byte = r_cmd.net[7:0];
                        5'd15:   cur_byte = i_cfg.radius;
                        default: cur_byte = i_cfg.tx_options;
                    endcase
                end
                default: begin
                    summed   = 1'b1;
                    cur_byte = r_cmd.data;
                end
            endcase
        end

        last      = is_csum || ((r_step == hdr_last) && !r_cmd.last);
        out_ready = !r_out_valid || i_out_pop;
        fire      = r_busy && out_ready;
        load      = (!r_busy || (fire && last)) && !i_cmd_empty;
        o_cmd_pop = load;

        n_cmd  = load ? i_cmd : r_cmd;
        n_busy = r_busy;
        n_step = r_step;
        if (load) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (fire) begin
            n_busy = !last;
            n_step = r_step + 5'd1;
        end

        n_sum = r_sum;
        if (fire && summed) begin
            n_sum = r_sum + cur_byte;
        end
        if (load && (i_cmd.kind != KIND_DATA)) begin
            n_sum = '0;
        end

        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_end   = r_out_end;
        if (fire) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_end   = is_csum;
        end else if (i_out_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_byte <= n_out_byte;
        r_out_end  <= n_out_end;
    end

    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_out_byte;
    assign o_frame_end = r_out_end;

endmodule

// ===== hw/rtl/api_frame_transmitter_unit.sv =====
// api frame transmitter: start items burst 3-4 (raw) or 17-18 (transmit) bytes,
// payload items 1 or 2; the sequencer emits one byte per cycle unless the output stalls, which sets the rate
// the first byte of an item passes the command queue, the sequencer command register and the output register
// input words are taken every cycle while the command queue has room
// reset is synchronous, active low: queue, frame state and output flushed,
// frame id back to 1, radius and options back to 0
module api_frame_transmitter_unit #(
    parameter int CMD_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word queue side
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_dest_address,
    input  logic [15:0] i_network_address,
    input  logic [15:0] i_payload_length,
    input  logic [7:0]  i_data_byte,
    // result queue side
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_end,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import afx_pkg::*;

    // configuration registers; user writes only while block is idle, not enforced
    logic [7:0] r_frame_id, n_frame_id;
    logic [7:0] r_radius, n_radius;
    logic [7:0] r_tx_options, n_tx_options;
    t_cfg       cfg;

    // front to queue, queue to back
    logic       accept;
    logic       front_push;
    t_cmd       front_cmd;
    logic       q_full, q_empty, q_pop;
    t_cmd       q_cmd;
    logic       out_valid;

    always_comb begin
        n_frame_id   = r_frame_id;
        n_radius     = r_radius;
        n_tx_options = r_tx_options;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_ID: n_frame_id   = i_cfg_data;
                CFG_RADIUS:   n_radius     = i_cfg_data;
                CFG_TX_OPTS:  n_tx_options = i_cfg_data;
                default:      n_frame_id   = r_frame_id;   // unused index, ignored
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_id   <= FRAME_ID_RESET;
            r_radius     <= '0;
            r_tx_options <= '0;
        end else begin
            r_frame_id   <= n_frame_id;
            r_radius     <= n_radius;
            r_tx_options <= n_tx_options;
        end
    end

    assign cfg.frame_id   = r_frame_id;
    assign cfg.radius     = r_radius;
    assign cfg.tx_options = r_tx_options;

    // every word is taken while the queue has room, even one that makes no output
    assign o_full = q_full;
    assign accept = i_push && !q_full;

    afx_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_operation       (i_operation),
        .i_dest_address    (i_dest_address),
        .i_network_address (i_network_address),
        .i_payload_length  (i_payload_length),
        .i_data_byte       (i_data_byte),
        .o_cmd_push        (front_push),
        .o_cmd             (front_cmd)
    );

    afx_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_cmd),
        .o_empty (q_empty)
    );

    // sequencer: one byte per cycle into the output register unless it stalls
    afx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (q_empty),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .i_cfg       (cfg),
        .i_out_pop   (i_pop),
        .o_out_valid (out_valid),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

    assign o_empty = !out_valid;

endmodule

// ===== hw/rtl/afx_checker.sv =====
// afx_checker: port-level assertions for the api frame transmitter
// depends on api_frame_transmitter_unit; bound to it at the end of this file
module afx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_push,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [7:0]  o_tx_byte,
    input logic        o_frame_end
);

    // reset flushes both sides
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not flushed after reset");

    // a waiting word carries known values
    a_word_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !$isunknown({o_tx_byte, o_frame_end}))
        else $error("waiting result word has unknown bits");

    // a waiting word stays until popped
    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> !o_empty)
        else $error("result word dropped without pop");

    a_payload_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> ($stable(o_tx_byte) && $stable(o_frame_end)))
        else $error("stalled result word changed");

endmodule

bind api_frame_transmitter_unit afx_checker u_afx_checker (.*);
